@@ hdl/assert_macros.svh @@
// assertion macros used by the compression engine of the sha-256 hasher rtl
// no dependencies; real checks in simulation, empty bodies for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sha256 hasher check failed");
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha256 hasher check failed");
`else
`define SHA_ASSERT(lbl, clk, rst_n, expr)
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/sha_pkg.sv @@
// shared types, constants and sigma functions for the sha-256 hasher
// no dependencies; used by the front end, compression engine and top level
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  // input item codes
  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // padding constants
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  // message word handed from the front end to the compression engine
  typedef struct packed {
    logic        digest;
    logic [31:0] word;
  } msg_word_t;

  // one digest word waiting for the result side
  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] word;
    logic        last;
  } dig_word_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // round function sigmas
  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // message schedule sigmas
  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

@@ hdl/sha_fifo.sv @@
// small first-in first-out queue of register entries
// no dependencies; used between the hasher stages and on the result side
`timescale 1ns / 1ps
`default_nettype none
module sha_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  // status and qualified transfers
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

@@ hdl/sha_front.sv @@
// front end: accepts bytes and finish items, pads, packs 32-bit words
// depends on sha_pkg; feeds the message word queue
`timescale 1ns / 1ps
`default_nettype none
module sha_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              in_mode,
  input  wire logic [7:0]        in_data_byte,
  output logic                   q_push,
  input  wire logic              q_full,
  output sha_pkg::msg_word_t     q_data
);

  typedef enum logic [2:0] {
    FR_DATA = 3'b001,
    FR_PAD  = 3'b010,
    FR_LEN  = 3'b100
  } front_state_t;

  front_state_t state_r;
  logic [5:0]   pos_r, pos_nxt;
  logic [23:0]  pack_r;
  logic [63:0]  cnt_r;
  logic [63:0]  len_r;
  logic         first_r;
  logic [2:0]   len_idx_r;
  logic         byte_room;
  logic         accept;
  logic         emit;
  logic [7:0]   emit_byte;

  // a byte can go out unless it closes a word and the queue is full
  assign byte_room = (pos_r[1:0] != 2'b11) || !q_full;
  assign full      = (state_r != FR_DATA) || !byte_room;
  assign accept    = push && !full;
  assign pos_nxt   = pos_r + 6'd1;

  // byte source for this cycle
  always_comb begin
    emit      = 1'b0;
    emit_byte = 8'h00;
    unique case (state_r)
      FR_DATA: begin
        emit      = accept && (in_mode == sha_pkg::MODE_ABSORB);
        emit_byte = in_data_byte;
      end
      FR_PAD: begin
        emit      = byte_room;
        emit_byte = first_r ? sha_pkg::PAD_BYTE : 8'h00;
      end
      FR_LEN: begin
        emit      = byte_room;
        emit_byte = len_r[63:56];
      end
      default: begin
        emit      = 1'b0;
        emit_byte = 8'h00;
      end
    endcase
  end

  // word transfer into the queue
  assign q_push      = emit && (pos_r[1:0] == 2'b11);
  assign q_data.word = {pack_r, emit_byte};
  assign q_data.digest = (state_r == FR_LEN) && (len_idx_r == 3'd7);

  // control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FR_DATA;
      pos_r     <= '0;
      cnt_r     <= '0;
      first_r   <= 1'b0;
      len_idx_r <= '0;
    end else begin
      if (emit) begin
        pos_r <= pos_nxt;
      end
      unique case (state_r)
        FR_DATA: begin
          if (accept) begin
            if (in_mode == sha_pkg::MODE_ABSORB) begin
              cnt_r <= cnt_r + 64'd1;
            end else begin
              first_r <= 1'b1;
              state_r <= FR_PAD;
            end
          end
        end
        FR_PAD: begin
          if (emit) begin
            first_r <= 1'b0;
            if (pos_nxt == sha_pkg::LEN_POS) begin
              len_idx_r <= '0;
              state_r   <= FR_LEN;
            end
          end
        end
        FR_LEN: begin
          if (emit) begin
            len_idx_r <= len_idx_r + 3'd1;
            if (len_idx_r == 3'd7) begin
              cnt_r   <= '0;
              state_r <= FR_DATA;
            end
          end
        end
        default: begin
          state_r <= FR_DATA;
        end
      endcase
    end
  end

  // word packing and bit length shifter
  always_ff @(posedge clk) begin
    if (emit) begin
      pack_r <= {pack_r[15:0], emit_byte};
    end
    if (state_r == FR_DATA && accept && in_mode == sha_pkg::MODE_FINISH) begin
      len_r <= {cnt_r[60:0], 3'b000};
    end else if (state_r == FR_LEN && emit) begin
      len_r <= {len_r[55:0], 8'h00};
    end
  end

endmodule
`default_nettype wire

@@ hdl/sha_back.sv @@
// compression engine: one round per cycle while message words are available, schedule window, digest output
// depends on sha_pkg and assert_macros.svh; drains the message word queue
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire sha_pkg::msg_word_t q_data,
  output logic                   q_pop,
  input  wire logic              o_full,
  output logic                   o_push,
  output sha_pkg::dig_word_t     o_data
);

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_ADD = 3'b010,
    ST_DIG = 3'b100
  } back_state_t;

  back_state_t state_r;
  logic [5:0]  rnd_r;
  logic [31:0] s_r [8];
  logic [31:0] h_r [8];
  logic [31:0] w_r [16];
  logic        dig_r;
  logic [2:0]  idx_r;
  logic        early;
  logic        step;
  logic [31:0] sched;
  logic [31:0] wi;
  logic [31:0] ch, maj, t1, t2;

  // message word: from the queue for the first sixteen rounds, else expanded
  assign early = !rnd_r[5] && !rnd_r[4];
  assign sched = w_r[0] + sha_pkg::small_sigma0(w_r[1]) + w_r[9]
               + sha_pkg::small_sigma1(w_r[14]);
  assign wi    = early ? q_data.word : sched;
  assign step  = (state_r == ST_RUN) && (!early || q_valid);
  assign q_pop = (state_r == ST_RUN) && early && q_valid;

  // round function
  assign ch  = (s_r[4] & s_r[5]) ^ (~s_r[4] & s_r[6]);
  assign maj = (s_r[0] & s_r[1]) ^ (s_r[0] & s_r[2]) ^ (s_r[1] & s_r[2]);
  assign t1  = s_r[7] + sha_pkg::big_sigma1(s_r[4]) + ch + sha_pkg::ROUND_K[rnd_r] + wi;
  assign t2  = sha_pkg::big_sigma0(s_r[0]) + maj;

  // digest transfer to the result queue
  assign o_push       = (state_r == ST_DIG) && !o_full;
  assign o_data.index = idx_r;
  assign o_data.word  = h_r[idx_r];
  assign o_data.last  = (idx_r == 3'd7);

  // sequencer, working variables and hash words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      rnd_r   <= '0;
      dig_r   <= 1'b0;
      idx_r   <= '0;
      for (int i = 0; i < 8; i++) begin
        s_r[i] <= sha_pkg::HASH_IV[i];
        h_r[i] <= sha_pkg::HASH_IV[i];
      end
    end else begin
      unique case (state_r)
        ST_RUN: begin
          if (step) begin
            s_r[0] <= t1 + t2;
            s_r[1] <= s_r[0];
            s_r[2] <= s_r[1];
            s_r[3] <= s_r[2];
            s_r[4] <= s_r[3] + t1;
            s_r[5] <= s_r[4];
            s_r[6] <= s_r[5];
            s_r[7] <= s_r[6];
            rnd_r  <= rnd_r + 6'd1;
            if (q_pop && rnd_r == 6'd15) begin
              dig_r <= q_data.digest;
            end
            if (rnd_r == 6'd63) begin
              state_r <= ST_ADD;
            end
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= h_r[i] + s_r[i];
            s_r[i] <= h_r[i] + s_r[i];
          end
          idx_r   <= '0;
          state_r <= dig_r ? ST_DIG : ST_RUN;
        end
        ST_DIG: begin
          if (o_push) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              dig_r   <= 1'b0;
              state_r <= ST_RUN;
              for (int i = 0; i < 8; i++) begin
                s_r[i] <= sha_pkg::HASH_IV[i];
                h_r[i] <= sha_pkg::HASH_IV[i];
              end
            end
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  // schedule window, oldest word at the bottom
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= wi;
    end
  end

  // checks
  `SHA_ASSERT_NEXT(a_last_round_adds, clk, rst_n, step && rnd_r == 6'd63, state_r == ST_ADD)
  `SHA_ASSERT_NEXT(a_digest_follows, clk, rst_n, state_r == ST_ADD && dig_r, state_r == ST_DIG)
  `SHA_ASSERT_NEXT(a_iv_after_digest, clk, rst_n, o_push && idx_r == 3'd7, h_r[0] == sha_pkg::HASH_IV[0] && rnd_r == 6'd0)
  `SHA_ASSERT(a_idx_idle, clk, rst_n, state_r == ST_DIG || idx_r == 3'd0)

endmodule
`default_nettype wire

@@ hdl/sha256_stream_hasher.sv @@
// top level of the streaming sha-256 hasher
// depends on sha_pkg, sha_fifo, sha_front and sha_back
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 over a byte stream. Push an item with mode 0 to absorb one byte,
// with mode 1 to finish the message; a finish yields eight digest words on
// the result queue, most significant first, last_word set on the eighth, and
// the block then starts a fresh message. Bytes are taken at most one per
// cycle. The compression engine spends 64 rounds plus the hash add on each
// 64-byte block, but only its first sixteen rounds overlap byte intake:
// during the 48 expanded rounds and the add, the front end stops once the
// message queue and its packing register are full; the default message
// queue depth is 4. A finish emits the padding and length bytes (9 to 72)
// one per cycle, subject to the same stalls, then the last block
// compressions, then one digest word per cycle while the result queue has
// room. While the front end pads, no new item is taken.
module sha256_stream_hasher #(
  parameter int MSG_QUEUE_DEPTH = 4,
  parameter int OUT_QUEUE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        pop,
  output logic             empty,
  output logic [2:0]       out_word_index,
  output logic [31:0]      out_digest_word,
  output logic             out_last_word
);

  sha_pkg::msg_word_t mq_wr_data, mq_rd_data;
  logic               mq_push, mq_full, mq_pop, mq_empty;
  sha_pkg::dig_word_t oq_wr_data, oq_rd_data;
  logic               oq_push, oq_full;

  // byte intake, padding and word packing
  sha_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .q_push       (mq_push),
    .q_full       (mq_full),
    .q_data       (mq_wr_data)
  );

  // message word queue between front end and engine
  sha_fifo #(
    .WIDTH ($bits(sha_pkg::msg_word_t)),
    .DEPTH (MSG_QUEUE_DEPTH)
  ) u_msg_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mq_push),
    .wr_data (mq_wr_data),
    .full    (mq_full),
    .rd_en   (mq_pop),
    .rd_data (mq_rd_data),
    .empty   (mq_empty)
  );

  // compression engine
  sha_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!mq_empty),
    .q_data  (mq_rd_data),
    .q_pop   (mq_pop),
    .o_full  (oq_full),
    .o_push  (oq_push),
    .o_data  (oq_wr_data)
  );

  // digest result queue
  sha_fifo #(
    .WIDTH ($bits(sha_pkg::dig_word_t)),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_push),
    .wr_data (oq_wr_data),
    .full    (oq_full),
    .rd_en   (pop),
    .rd_data (oq_rd_data),
    .empty   (empty)
  );

  assign out_word_index  = oq_rd_data.index;
  assign out_digest_word = oq_rd_data.word;
  assign out_last_word   = oq_rd_data.last;

endmodule
`default_nettype wire
